// ===== design/lzwd_pkg.sv =====
// shared types and constants of the lzw code decoder
`default_nettype none

package lzwd_pkg;

    localparam int LITERAL_CODES    = 256;
    localparam int BYTES_PER_PACKET = 8;
    localparam int CODE_W           = 9;
    localparam int NFC_W            = 10;
    localparam int LEN_W            = 9;
    localparam int CNT_W            = 4;
    localparam int DICT_DEPTH       = 256;
    localparam int DICT_AW          = 8;
    localparam int BUF_WORDS        = 64;
    localparam int BUF_WAW          = 6;
    localparam int LANE_W           = 3;

    typedef struct packed {
        logic [CODE_W-1:0] prefix;
        logic [7:0]        suffix;
        logic [LEN_W-1:0]  length;
    } t_dict_entry;

    typedef struct packed {
        logic               en;
        logic [DICT_AW-1:0] addr;
        t_dict_entry        data;
    } t_dict_wr;

    typedef struct packed {
        logic             en;
        logic [LEN_W-1:0] pos;
        logic [7:0]       data;
    } t_buf_wr;

    typedef logic [BYTES_PER_PACKET-1:0][7:0] t_word;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_WALK = 4'b0010,
        ST_EMIT = 4'b0100,
        ST_ERR  = 4'b1000
    } t_state;

endpackage

`default_nettype wire

// ===== design/lzwd_if.sv =====
// valid/ready channels of the lzw code decoder
`default_nettype none

interface lzwd_in_if;
    logic       valid;
    logic       ready;
    logic [8:0] code;
    logic       restart;

    modport source (output valid, output code, output restart, input ready);
    modport sink (input valid, input code, input restart, output ready);
endinterface

interface lzwd_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte0;
    logic [7:0] out_byte1;
    logic [7:0] out_byte2;
    logic [7:0] out_byte3;
    logic [7:0] out_byte4;
    logic [7:0] out_byte5;
    logic [7:0] out_byte6;
    logic [7:0] out_byte7;
    logic [3:0] byte_count;
    logic       last_packet;
    logic       code_error;

    modport source (
        output valid, input ready,
        output out_byte0, output out_byte1, output out_byte2, output out_byte3,
        output out_byte4, output out_byte5, output out_byte6, output out_byte7,
        output byte_count, output last_packet, output code_error
    );
    modport sink (
        input valid, output ready,
        input out_byte0, input out_byte1, input out_byte2, input out_byte3,
        input out_byte4, input out_byte5, input out_byte6, input out_byte7,
        input byte_count, input last_packet, input code_error
    );
endinterface

`default_nettype wire

// ===== design/lzw_code_decoder.sv =====
// lzw code decoder top level: sequencer, chain walk, packet output register
//
//   channel   dir   payload                                     accepted when
//   i_code    in    code[8:0], restart                          valid && ready
//   o_pkt     out   out_byte0..7, byte_count, last_packet,      valid && ready
//                   code_error
//
// a code is accepted, then its prefix chain is walked byte by byte through the
// single read port of the dictionary memory (for a code equal to the next free
// slot the trailing byte is written at accept), the string buffer read is
// primed, and the string goes out one word per packet; an error code waits
// for a free output register; a new word is taken once the last packet sits
// in the output register, so it overlaps with a stalled sink
// synchronous active-low reset; empty dictionary after reset, no clearing pass
// a stalled sink holds the packet and the sequencer waits in the emit or error state
`default_nettype none

module lzw_code_decoder #(
    parameter int DICT_ENTRIES = 512
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    lzwd_in_if.sink   i_code,
    lzwd_out_if.source o_pkt
);

    localparam int CW  = lzwd_pkg::CODE_W;
    localparam int NW  = lzwd_pkg::NFC_W;
    localparam int LW  = lzwd_pkg::LEN_W;
    localparam int BPP = lzwd_pkg::BYTES_PER_PACKET;

    // sequencer state
    lzwd_pkg::t_state r_state, n_state;

    // decoder state
    logic [NW-1:0] r_nfc, n_nfc;
    logic [CW-1:0] r_prev, n_prev;
    logic [7:0]    r_prev_first, n_prev_first;
    logic [LW-1:0] r_prev_len, n_prev_len;
    logic          r_await, n_await;

    // per-code walk state
    logic [CW-1:0] r_code, n_code;
    logic [CW-1:0] r_cur, n_cur;
    logic [LW-1:0] r_pos, n_pos;
    logic [LW-1:0] r_total, n_total;
    logic          r_first, n_first;
    logic          r_add, n_add;

    // packet emission
    logic [LW-1:0]                r_rem, n_rem;
    logic [lzwd_pkg::BUF_WAW-1:0] r_widx, n_widx;
    logic                         r_rd_ok, n_rd_ok;

    // output register
    logic                     r_out_valid, n_out_valid;
    lzwd_pkg::t_word          r_out_bytes, n_out_bytes;
    logic [lzwd_pkg::CNT_W-1:0] r_out_cnt, n_out_cnt;
    logic                     r_out_last, n_out_last;
    logic                     r_out_err, n_out_err;

    // memory ports
    lzwd_pkg::t_dict_wr           w_dict_wr;
    logic [lzwd_pkg::DICT_AW-1:0] w_dict_rd_addr;
    lzwd_pkg::t_dict_entry        w_dict_rd;
    lzwd_pkg::t_buf_wr            w_buf_wr;
    logic [lzwd_pkg::BUF_WAW-1:0] w_buf_rd_word;
    lzwd_pkg::t_word              w_buf_rd;

    // accept-time decode
    logic          w_in_acc;
    logic [NW-1:0] w_eff_nfc;
    logic          w_eff_await;
    logic [NW-1:0] w_code_ext;
    logic          w_code_lit;
    logic          w_is_first;
    logic          w_is_norm;
    logic          w_is_spec;
    logic          w_room;

    // walk step
    logic          w_cur_lit;
    logic [LW-1:0] w_pos_eff;
    logic [LW-1:0] w_total_eff;
    logic [7:0]    w_byte;
    logic          w_walk_done;

    // emission
    logic                       w_out_free;
    logic                       w_load;
    logic [lzwd_pkg::CNT_W-1:0] w_pkt_cnt;
    logic                       w_pkt_last;
    lzwd_pkg::t_word            w_pkt_bytes;

    lzwd_dict_ram u_dict (
        .i_clk     (i_clk),
        .i_wr      (w_dict_wr),
        .i_rd_addr (w_dict_rd_addr),
        .o_rd_data (w_dict_rd)
    );

    lzwd_str_buf u_buf (
        .i_clk     (i_clk),
        .i_wr      (w_buf_wr),
        .i_rd_word (w_buf_rd_word),
        .o_rd_data (w_buf_rd)
    );

    // restart takes effect before the code is looked at
    assign w_in_acc    = i_code.valid && i_code.ready;
    assign w_eff_nfc   = i_code.restart ? NW'(lzwd_pkg::LITERAL_CODES) : r_nfc;
    assign w_eff_await = i_code.restart || r_await;
    assign w_code_ext  = NW'(i_code.code);
    assign w_code_lit  = w_code_ext < NW'(lzwd_pkg::LITERAL_CODES);
    assign w_room      = w_eff_nfc < NW'(DICT_ENTRIES);
    assign w_is_first  = w_eff_await && w_code_lit;
    assign w_is_norm   = !w_eff_await && (w_code_ext < w_eff_nfc);
    // code equal to the next free slot: previous string plus its own first byte
    assign w_is_spec   = !w_eff_await && (w_code_ext == w_eff_nfc) && w_room;

    // one chain step: the read issued last cycle returned the entry for r_cur
    assign w_cur_lit   = r_cur < CW'(lzwd_pkg::LITERAL_CODES);
    assign w_pos_eff   = (!w_cur_lit && r_first) ? LW'(w_dict_rd.length - LW'(1)) : r_pos;
    assign w_total_eff = (!w_cur_lit && r_first) ? w_dict_rd.length : r_total;
    assign w_byte      = w_cur_lit ? r_cur[7:0] : w_dict_rd.suffix;
    assign w_walk_done = w_cur_lit || (w_pos_eff == '0);

    // packet forming from the buffered word
    assign w_out_free = !r_out_valid || o_pkt.ready;
    assign w_load     = (r_state == lzwd_pkg::ST_EMIT) && r_rd_ok && w_out_free;
    assign w_pkt_last = r_rem <= LW'(BPP);
    assign w_pkt_cnt  = w_pkt_last ? r_rem[lzwd_pkg::CNT_W-1:0] : lzwd_pkg::CNT_W'(BPP);

    always_comb begin
        for (int b = 0; b < BPP; b++) begin
            w_pkt_bytes[b] = (lzwd_pkg::CNT_W'(b) < w_pkt_cnt) ? w_buf_rd[b] : 8'h00;
        end
    end

    // string buffer read: advance as soon as a word is taken
    assign w_buf_rd_word = w_load ? lzwd_pkg::BUF_WAW'(r_widx + lzwd_pkg::BUF_WAW'(1)) : r_widx;

    // dictionary read: the code itself or the previous code at accept, then prefixes
    assign w_dict_rd_addr = (r_state == lzwd_pkg::ST_IDLE) ?
                            (w_is_spec ? r_prev[lzwd_pkg::DICT_AW-1:0]
                                       : i_code.code[lzwd_pkg::DICT_AW-1:0]) :
                            w_dict_rd.prefix[lzwd_pkg::DICT_AW-1:0];

    assign i_code.ready = (r_state == lzwd_pkg::ST_IDLE);

    always_comb begin
        n_state      = r_state;
        n_nfc        = r_nfc;
        n_prev       = r_prev;
        n_prev_first = r_prev_first;
        n_prev_len   = r_prev_len;
        n_await      = r_await;
        n_code       = r_code;
        n_cur        = r_cur;
        n_pos        = r_pos;
        n_total      = r_total;
        n_first      = r_first;
        n_add        = r_add;
        n_rem        = r_rem;
        n_widx       = r_widx;
        n_rd_ok      = r_rd_ok;
        n_out_valid  = r_out_valid && !o_pkt.ready;
        n_out_bytes  = r_out_bytes;
        n_out_cnt    = r_out_cnt;
        n_out_last   = r_out_last;
        n_out_err    = r_out_err;
        w_dict_wr    = '0;
        w_buf_wr     = '0;

        unique case (r_state)
            lzwd_pkg::ST_IDLE: begin
                if (w_in_acc) begin
                    n_nfc   = w_eff_nfc;
                    n_await = w_is_first ? 1'b0 : w_eff_await;
                    n_code  = i_code.code;
                    n_add   = !w_eff_await && w_room;
                    if (w_is_first || (w_is_norm && w_code_lit)) begin
                        // single literal byte
                        n_cur   = i_code.code;
                        n_pos   = '0;
                        n_total = LW'(1);
                        n_first = 1'b0;
                        n_state = lzwd_pkg::ST_WALK;
                    end else if (w_is_norm) begin
                        // position and length come with the first entry read
                        n_cur   = i_code.code;
                        n_first = 1'b1;
                        n_state = lzwd_pkg::ST_WALK;
                    end else if (w_is_spec) begin
                        // trailing byte goes in now, then walk the previous string
                        w_buf_wr.en   = 1'b1;
                        w_buf_wr.pos  = r_prev_len;
                        w_buf_wr.data = r_prev_first;
                        n_cur   = r_prev;
                        n_pos   = LW'(r_prev_len - LW'(1));
                        n_total = LW'(r_prev_len + LW'(1));
                        n_first = 1'b0;
                        n_state = lzwd_pkg::ST_WALK;
                    end else begin
                        n_state = lzwd_pkg::ST_ERR;
                    end
                end
            end

            lzwd_pkg::ST_WALK: begin
                w_buf_wr.en   = 1'b1;
                w_buf_wr.pos  = w_pos_eff;
                w_buf_wr.data = w_byte;
                if (w_walk_done) begin
                    // grow the dictionary once the first byte is known
                    w_dict_wr.en          = r_add;
                    w_dict_wr.addr        = r_nfc[lzwd_pkg::DICT_AW-1:0];
                    w_dict_wr.data.prefix = r_prev;
                    w_dict_wr.data.suffix = w_byte;
                    w_dict_wr.data.length = LW'(r_prev_len + LW'(1));
                    n_nfc        = NW'(r_nfc + NW'(r_add));
                    n_prev       = r_code;
                    n_prev_first = w_byte;
                    n_prev_len   = w_total_eff;
                    n_rem        = w_total_eff;
                    n_widx       = '0;
                    n_rd_ok      = 1'b0;
                    n_state      = lzwd_pkg::ST_EMIT;
                end else begin
                    n_pos   = LW'(w_pos_eff - LW'(1));
                    n_cur   = w_dict_rd.prefix;
                    n_total = w_total_eff;
                    n_first = 1'b0;
                end
            end

            lzwd_pkg::ST_EMIT: begin
                n_rd_ok = 1'b1;
                if (w_load) begin
                    n_out_valid = 1'b1;
                    n_out_bytes = w_pkt_bytes;
                    n_out_cnt   = w_pkt_cnt;
                    n_out_last  = w_pkt_last;
                    n_out_err   = 1'b0;
                    n_rem       = LW'(r_rem - LW'(BPP));
                    n_widx      = w_buf_rd_word;
                    if (w_pkt_last) begin
                        n_state = lzwd_pkg::ST_IDLE;
                    end
                end
            end

            lzwd_pkg::ST_ERR: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_bytes = '0;
                    n_out_cnt   = '0;
                    n_out_last  = 1'b1;
                    n_out_err   = 1'b1;
                    n_state     = lzwd_pkg::ST_IDLE;
                end
            end

            default: begin
                n_state = lzwd_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= lzwd_pkg::ST_IDLE;
            r_nfc        <= NW'(lzwd_pkg::LITERAL_CODES);
            r_prev       <= '0;
            r_prev_first <= '0;
            r_prev_len   <= '0;
            r_await      <= 1'b1;
            r_rd_ok      <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_nfc        <= n_nfc;
            r_prev       <= n_prev;
            r_prev_first <= n_prev_first;
            r_prev_len   <= n_prev_len;
            r_await      <= n_await;
            r_rd_ok      <= n_rd_ok;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_code      <= n_code;
        r_cur       <= n_cur;
        r_pos       <= n_pos;
        r_total     <= n_total;
        r_first     <= n_first;
        r_add       <= n_add;
        r_rem       <= n_rem;
        r_widx      <= n_widx;
        r_out_bytes <= n_out_bytes;
        r_out_cnt   <= n_out_cnt;
        r_out_last  <= n_out_last;
        r_out_err   <= n_out_err;
    end

    assign o_pkt.valid       = r_out_valid;
    assign o_pkt.out_byte0   = r_out_bytes[0];
    assign o_pkt.out_byte1   = r_out_bytes[1];
    assign o_pkt.out_byte2   = r_out_bytes[2];
    assign o_pkt.out_byte3   = r_out_bytes[3];
    assign o_pkt.out_byte4   = r_out_bytes[4];
    assign o_pkt.out_byte5   = r_out_bytes[5];
    assign o_pkt.out_byte6   = r_out_bytes[6];
    assign o_pkt.out_byte7   = r_out_bytes[7];
    assign o_pkt.byte_count  = r_out_cnt;
    assign o_pkt.last_packet = r_out_last;
    assign o_pkt.code_error  = r_out_err;

    // next free slot stays between the first dictionary code and the table size
    a_nfc_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_nfc >= NW'(lzwd_pkg::LITERAL_CODES)) && (r_nfc <= NW'(DICT_ENTRIES)))
        else $error("next free code out of range");

    // end of walk hands over to emission with the buffer read not yet primed
    a_walk_to_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == lzwd_pkg::ST_WALK) && w_walk_done
        |=> (r_state == lzwd_pkg::ST_EMIT) && !r_rd_ok)
        else $error("walk did not hand over to emission");

    // emission never runs with nothing left to send
    a_emit_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == lzwd_pkg::ST_EMIT) |-> (r_rem != '0))
        else $error("emission with empty remainder");

    // an error packet carries no bytes and closes the code
    a_err_pkt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_err |-> (r_out_cnt == '0) && r_out_last)
        else $error("malformed error packet");

endmodule

`default_nettype wire

// ===== design/lzwd_dict_ram.sv =====
// dictionary memory: prefix, suffix and length per entry, one write and one registered read
`default_nettype none

module lzwd_dict_ram (
    input  wire logic                         i_clk,
    input  wire lzwd_pkg::t_dict_wr           i_wr,
    input  wire logic [lzwd_pkg::DICT_AW-1:0] i_rd_addr,
    output lzwd_pkg::t_dict_entry             o_rd_data
);

    lzwd_pkg::t_dict_entry r_mem [lzwd_pkg::DICT_DEPTH];
    lzwd_pkg::t_dict_entry r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

// ===== design/lzwd_str_buf.sv =====
// string buffer: byte-lane writes, registered eight-byte word reads
`default_nettype none

module lzwd_str_buf (
    input  wire logic                         i_clk,
    input  wire lzwd_pkg::t_buf_wr            i_wr,
    input  wire logic [lzwd_pkg::BUF_WAW-1:0] i_rd_word,
    output lzwd_pkg::t_word                   o_rd_data
);

    lzwd_pkg::t_word r_mem [lzwd_pkg::BUF_WORDS];
    lzwd_pkg::t_word r_rd_data;

    logic [lzwd_pkg::BUF_WAW-1:0] w_wr_word;
    logic [lzwd_pkg::LANE_W-1:0]  w_wr_lane;

    assign w_wr_word = i_wr.pos[lzwd_pkg::LEN_W-1:lzwd_pkg::LANE_W];
    assign w_wr_lane = i_wr.pos[lzwd_pkg::LANE_W-1:0];

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[w_wr_word][w_wr_lane] <= i_wr.data;
        end
        r_rd_data <= r_mem[i_rd_word];
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

// ===== verif/lzw_code_decoder_test.sv =====
// self-checking testbench of the lzw code decoder: directed and random code streams
`timescale 1ns / 1ps

module lzw_code_decoder_test;
    import lzwd_pkg::*;

    localparam int DICT_ENTRIES   = 512;
    localparam int IDLE_MAX       = 8;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int TAIL_CYCLES    = 300;
    localparam int REPORT_MAX     = 10;

    typedef struct packed {
        t_word            bytes;
        logic [CNT_W-1:0] count;
        logic             last_pkt;
        logic             err;
    } t_packet;

    logic i_clk = 1'b0;
    logic i_rst_n;

    lzwd_in_if  in_ch ();
    lzwd_out_if out_ch ();

    lzw_code_decoder #(
        .DICT_ENTRIES(DICT_ENTRIES)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_code (in_ch.sink),
        .o_pkt  (out_ch.source)
    );

    always #5 i_clk = ~i_clk;

    // mirror of the decoder dictionary and stream state
    logic [CODE_W-1:0] entry_prefix [DICT_DEPTH];
    logic [7:0]        entry_suffix [DICT_DEPTH];
    logic [LEN_W-1:0]  entry_len    [DICT_DEPTH];
    int unsigned       next_free;
    logic [CODE_W-1:0] prev_code;
    logic [7:0]        prev_first;
    bit                awaiting_first;
    logic [7:0]        spelled [512];

    t_packet     expected_pkts [$];
    int unsigned fail_count   = 0;
    int unsigned quiet_cycles = 0;
    bit          idle_on;

    function automatic void clear_stream_state();
        next_free      = LITERAL_CODES;
        prev_code      = '0;
        prev_first     = '0;
        awaiting_first = 1'b1;
    endfunction

    function automatic int unsigned string_len(logic [CODE_W-1:0] c);
        if (c < LITERAL_CODES) return 1;
        return entry_len[c[DICT_AW-1:0]];
    endfunction

    // walk the prefix chain backwards, filling spelled[] from the end
    function automatic int unsigned spell_code(logic [CODE_W-1:0] c);
        int unsigned len;
        int unsigned pos;
        len = string_len(c);
        pos = len;
        while (pos > 0) begin
            pos--;
            if (c < LITERAL_CODES) begin
                spelled[pos] = c[7:0];
                break;
            end
            spelled[pos] = entry_suffix[c[DICT_AW-1:0]];
            c = entry_prefix[c[DICT_AW-1:0]];
        end
        return len;
    endfunction

    function automatic void queue_string(int unsigned len);
        t_packet     p;
        int unsigned base;
        for (base = 0; base < len; base += BYTES_PER_PACKET) begin
            p = '0;
            for (int b = 0; b < BYTES_PER_PACKET; b++) begin
                if (base + b < len) p.bytes[b] = spelled[base + b];
            end
            p.count    = CNT_W'((len - base > BYTES_PER_PACKET) ? BYTES_PER_PACKET : len - base);
            p.last_pkt = (base + BYTES_PER_PACKET >= len);
            expected_pkts = {expected_pkts, p};
        end
    endfunction

    function automatic void queue_error();
        t_packet p;
        p          = '0;
        p.last_pkt = 1'b1;
        p.err      = 1'b1;
        expected_pkts = {expected_pkts, p};
    endfunction

    // expected packets of one accepted code, and the dictionary update it causes
    function automatic void decode_code(logic [CODE_W-1:0] c, logic restart);
        int unsigned        len;
        logic [DICT_AW-1:0] slot;
        if (restart) begin
            next_free      = LITERAL_CODES;
            awaiting_first = 1'b1;
        end
        if (awaiting_first) begin
            if (c >= LITERAL_CODES) begin
                queue_error();
                return;
            end
            spelled[0]     = c[7:0];
            prev_code      = c;
            prev_first     = c[7:0];
            awaiting_first = 1'b0;
            queue_string(1);
            return;
        end
        if (c < next_free) begin
            len = spell_code(c);
        end else if (c == next_free && next_free < DICT_ENTRIES) begin
            // code not yet in the dictionary: previous string plus its own first byte
            len = spell_code(prev_code);
            spelled[len] = prev_first;
            len++;
        end else begin
            queue_error();
            return;
        end
        if (next_free < DICT_ENTRIES) begin
            slot               = DICT_AW'(next_free - LITERAL_CODES);
            entry_prefix[slot] = prev_code;
            entry_suffix[slot] = spelled[0];
            entry_len[slot]    = LEN_W'(string_len(prev_code) + 1);
            next_free++;
        end
        prev_code  = c;
        prev_first = spelled[0];
        queue_string(len);
    endfunction

    // one code word onto the input channel, predicted when accepted
    task automatic send_code(input logic [CODE_W-1:0] c, input logic restart);
        int unsigned gap;
        gap = idle_on ? $urandom_range(0, IDLE_MAX) : 0;
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.code    <= c;
        in_ch.restart <= restart;
        do @(posedge i_clk); while (!in_ch.ready);
        decode_code(c, restart);
    endtask

    // hold the input channel quiet until every expected packet is out
    task automatic wait_for_results();
        in_ch.valid <= 1'b0;
        do @(posedge i_clk); while (expected_pkts.size() != 0);
    endtask

    function automatic logic [CODE_W-1:0] pick_code(int unsigned noise_pct);
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < noise_pct) begin
            if (next_free < DICT_ENTRIES - 1) return CODE_W'($urandom_range(next_free + 1, 511));
            return CODE_W'($urandom_range(0, 511));
        end
        roll = $urandom_range(0, 99);
        if (roll < 25) return CODE_W'($urandom_range(0, 255));
        if (roll < 60) begin
            // newest entries, so strings keep growing
            if (next_free < DICT_ENTRIES &&
                ($urandom_range(0, 1) == 1 || next_free == LITERAL_CODES))
                return CODE_W'(next_free);
            return CODE_W'(next_free - 1);
        end
        if (next_free > LITERAL_CODES)
            return CODE_W'($urandom_range(LITERAL_CODES, next_free - 1));
        return CODE_W'($urandom_range(0, 255));
    endfunction

    task automatic run_stream(input int unsigned n, input int unsigned noise_pct,
                              input bit restarts);
        idle_on = ($urandom_range(0, 3) != 0);
        if ($urandom_range(0, 99) < 85)
            send_code(CODE_W'($urandom_range(0, 255)), 1'b1);
        else
            send_code(CODE_W'($urandom_range(256, 511)), 1'b1);
        repeat (n) begin
            if (restarts && $urandom_range(0, 99) < 3)
                send_code(CODE_W'($urandom_range(0, 511)), 1'b1);
            else
                send_code(pick_code(noise_pct), 1'b0);
        end
    endtask

    task automatic test_bad_first_code();
        send_code(9'd300, 1'b0);
        send_code(9'd511, 1'b0);
        send_code(9'd256, 1'b1);    // restart still clears, then errors
        send_code(9'd0, 1'b1);
    endtask

    task automatic test_literals();
        send_code(9'd255, 1'b0);
        send_code(9'd170, 1'b0);
        send_code(9'd85, 1'b0);
        send_code(CODE_W'(next_free), 1'b0);
        send_code(9'd256, 1'b0);
    endtask

    task automatic test_out_of_range();
        send_code(CODE_W'(next_free + 1), 1'b0);
        send_code(9'd511, 1'b0);
        send_code(CODE_W'(next_free), 1'b0);    // state untouched by the errors
    endtask

    task automatic test_restart_mid_stream();
        send_code(9'd255, 1'b1);
        send_code(CODE_W'(next_free), 1'b0);    // not-yet-defined code right after first
        send_code(9'd256, 1'b0);
    endtask

    task automatic test_long_chain();
        // lengths 3 to 12 cross the packet boundary
        repeat (10) send_code(CODE_W'(next_free), 1'b0);
    endtask

    task automatic test_random_streams();
        repeat (3) run_stream(18, 12, 1'b1);
        run_stream(290, 3, 1'b0);               // long enough to fill the dictionary
        repeat (3) run_stream(18, 12, 1'b1);
    endtask

    task automatic note_failure(input string what, input t_packet want, input t_packet got);
        fail_count++;
        if (fail_count <= REPORT_MAX)
            $display(
                "%s: expected %h cnt=%0d last=%0b err=%0b, got %h cnt=%0d last=%0b err=%0b",
                what, want.bytes, want.count, want.last_pkt, want.err,
                got.bytes, got.count, got.last_pkt, got.err);
    endtask

    // output side: random stalls, each accepted packet checked against the oldest expectation
    initial begin
        t_packet     want;
        t_packet     got;
        int unsigned stall;
        out_ch.ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            stall = idle_on ? $urandom_range(0, IDLE_MAX) : 0;
            if (stall > 0) begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!out_ch.valid);
            got.bytes    = {out_ch.out_byte7, out_ch.out_byte6, out_ch.out_byte5,
                            out_ch.out_byte4, out_ch.out_byte3, out_ch.out_byte2,
                            out_ch.out_byte1, out_ch.out_byte0};
            got.count    = out_ch.byte_count;
            got.last_pkt = out_ch.last_packet;
            got.err      = out_ch.code_error;
            if (expected_pkts.size() == 0) begin
                note_failure("unexpected word", '0, got);
            end else begin
                want = expected_pkts.pop_front();
                if (got !== want) note_failure("mismatch", want, got);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("FAIL lzw_code_decoder");
                $finish;
            end
        end
    end

    initial begin
        in_ch.valid   <= 1'b0;
        in_ch.code    <= '0;
        in_ch.restart <= 1'b0;
        i_rst_n       <= 1'b0;
        idle_on = 1'b1;
        clear_stream_state();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_bad_first_code();
        test_literals();
        test_out_of_range();
        wait_for_results();
        test_restart_mid_stream();
        test_long_chain();
        test_random_streams();

        wait_for_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_count == 0)
            $display("PASS lzw_code_decoder");
        else
            $display("FAIL lzw_code_decoder");
        $finish;
    end

endmodule
